@@ hw/rtl/dqsa_pkg.sv @@
// ----------------------------------------------------------------------------
// dqsa_pkg
// Shared types and constants for the dual queue in a shared array.
// ----------------------------------------------------------------------------
package dqsa_pkg;

  // Default number of words in the shared memory.
  localparam int unsigned DqsaDepth = 128;

  // Width of one stored word.
  localparam int unsigned DataW = 32;

  // Request kinds carried in the input tuser.
  typedef enum logic {
    REQ_ENQ = 1'b0,
    REQ_DEQ = 1'b1
  } req_type_e;

  // Result status codes carried in the output tuser.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  // Controller states.
  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // a request is taken at this edge
    logic load_now;  // load the result register from the request decode
    logic load_ram;  // load the result register from the memory read data
  } dqsa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic deq_hit;   // pending request is a dequeue from a non-empty queue
    logic out_busy;  // result register holds a result that is not taken now
  } dqsa_sts_t;

endpackage

@@ hw/rtl/dqsa_ram.sv @@
// ----------------------------------------------------------------------------
// dqsa_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module dqsa_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 128,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/dqsa_ctrl.sv @@
// ----------------------------------------------------------------------------
// dqsa_ctrl
// Request sequencer: takes requests and waits out the memory read of a dequeue.
// ----------------------------------------------------------------------------
module dqsa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  dqsa_pkg::dqsa_sts_t sts_i,
  output dqsa_pkg::dqsa_cmd_t cmd_o
);
  import dqsa_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i && ready && sts_i.deq_hit) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    ready        = 1'b0;
    cmd_o        = '0;
    unique case (state_q)
      S_IDLE: begin
        ready          = !sts_i.out_busy;
        cmd_o.accept   = req_valid_i && ready;
        cmd_o.load_now = req_valid_i && ready && !sts_i.deq_hit;
      end
      S_READ: begin
        cmd_o.load_ram = 1'b1;
      end
      default: begin
        ready = 1'b0;
      end
    endcase
  end

  assign req_ready_o = ready;

endmodule

@@ hw/rtl/dqsa_dp.sv @@
// ----------------------------------------------------------------------------
// dqsa_dp
// Queue pointers, shared memory and result register.
// ----------------------------------------------------------------------------
module dqsa_dp #(
  parameter int unsigned Depth = dqsa_pkg::DqsaDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       req_type_i,
  input  logic                       queue_sel_i,
  input  logic [dqsa_pkg::DataW-1:0] value_i,
  input  dqsa_pkg::dqsa_cmd_t        cmd_i,
  output dqsa_pkg::dqsa_sts_t        sts_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [1:0]                 status_o,
  output logic [dqsa_pkg::DataW-1:0] data_o
);
  import dqsa_pkg::*;

  localparam int unsigned AW = $clog2(Depth);
  localparam logic [AW-1:0] TopIdx = AW'(Depth - 1);

  logic [AW-1:0] head_a_q, head_a_d, tail_a_q, tail_a_d;
  logic [AW-1:0] head_b_q, head_b_d, tail_b_q, tail_b_d;
  logic          empty_a_q, empty_a_d, empty_b_q, empty_b_d;

  logic          is_deq, sel_b, sel_empty, full, enq_ok, deq_hit;
  logic [AW:0]   top_a, bot_b;
  status_e       status_now;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [DataW-1:0] rdata;

  logic             out_valid_q;
  status_e          status_q;
  logic [DataW-1:0] data_q;

  // Request decode.
  always_comb begin
    is_deq    = (req_type_i == REQ_DEQ);
    sel_b     = queue_sel_i;
    sel_empty = sel_b ? empty_b_q : empty_a_q;
    top_a     = empty_a_q ? '0 : ({1'b0, tail_a_q} + (AW+1)'(1));
    bot_b     = empty_b_q ? (AW+1)'(Depth) : {1'b0, tail_b_q};
    full      = (top_a >= bot_b);
    enq_ok    = !is_deq && !full;
    deq_hit   = is_deq && !sel_empty;
    if (is_deq) begin
      status_now = sel_empty ? ST_UNDERFLOW : ST_OK;
    end else begin
      status_now = full ? ST_OVERFLOW : ST_OK;
    end
  end

  // Pointer updates and memory access.
  always_comb begin
    head_a_d  = head_a_q;
    tail_a_d  = tail_a_q;
    empty_a_d = empty_a_q;
    head_b_d  = head_b_q;
    tail_b_d  = tail_b_q;
    empty_b_d = empty_b_q;
    we        = 1'b0;
    re        = 1'b0;
    waddr     = '0;
    raddr     = sel_b ? head_b_q : head_a_q;
    if (cmd_i.accept && enq_ok) begin
      we = 1'b1;
      if (!sel_b) begin
        empty_a_d = 1'b0;
        if (empty_a_q) begin
          head_a_d = '0;
          tail_a_d = '0;
        end else begin
          tail_a_d = tail_a_q + AW'(1);
        end
        waddr = tail_a_d;
      end else begin
        empty_b_d = 1'b0;
        if (empty_b_q) begin
          head_b_d = TopIdx;
          tail_b_d = TopIdx;
        end else begin
          tail_b_d = tail_b_q - AW'(1);
        end
        waddr = tail_b_d;
      end
    end else if (cmd_i.accept && deq_hit) begin
      re = 1'b1;
      if (!sel_b) begin
        if (head_a_q == tail_a_q) begin
          head_a_d  = '0;
          tail_a_d  = '0;
          empty_a_d = 1'b1;
        end else begin
          head_a_d = head_a_q + AW'(1);
        end
      end else begin
        if (head_b_q == tail_b_q) begin
          head_b_d  = TopIdx;
          tail_b_d  = TopIdx;
          empty_b_d = 1'b1;
        end else begin
          head_b_d = head_b_q - AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_a_q  <= '0;
      tail_a_q  <= '0;
      empty_a_q <= 1'b1;
      head_b_q  <= TopIdx;
      tail_b_q  <= TopIdx;
      empty_b_q <= 1'b1;
    end else begin
      head_a_q  <= head_a_d;
      tail_a_q  <= tail_a_d;
      empty_a_q <= empty_a_d;
      head_b_q  <= head_b_d;
      tail_b_q  <= tail_b_d;
      empty_b_q <= empty_b_d;
    end
  end

  dqsa_ram #(
    .Width (DataW),
    .Depth (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (value_i),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_now || cmd_i.load_ram) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_now) begin
      status_q <= status_now;
      data_q   <= '0;
    end else if (cmd_i.load_ram) begin
      status_q <= ST_OK;
      data_q   <= rdata;
    end
  end

  assign sts_o.deq_hit  = deq_hit;
  assign sts_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign data_o         = data_q;

`ifndef SYNTHESIS
  // An empty queue keeps its pointers at their home slot.
  a_empty_a_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_a_q |-> (head_a_q == '0) && (tail_a_q == '0))
    else $error("queue A empty with pointers away from slot zero");

  a_empty_b_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_b_q |-> (head_b_q == TopIdx) && (tail_b_q == TopIdx))
    else $error("queue B empty with pointers away from the top slot");

  // Live queue contents never cross each other.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_a_q && !empty_b_q) |-> (tail_a_q < tail_b_q))
    else $error("queue A and queue B overlap in the shared memory");

  // A memory read result is only loaded right after a dequeue was taken.
  a_ram_load_follows_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_ram |-> $past(re))
    else $error("result loaded from memory without a preceding read");
`endif

endmodule

@@ hw/rtl/dual_queue_shared_array.sv @@
// ----------------------------------------------------------------------------
// dual_queue_shared_array
// Two linear FIFO queues sharing one memory: A grows up, B grows down.
// ----------------------------------------------------------------------------
// Timing: an enqueue or a refused request shows its result in the cycle after
// acceptance; a successful dequeue shows it once the head word has passed the
// memory's registered read port and the controller's read state. Throughput:
// one request per cycle for enqueues and refusals while the result register is
// free or being emptied; in its read state, while it waits for the read data,
// the controller takes no new request. Reset: asynchronous, active low; both
// queues come up empty and no result is pending. The memory is not cleared.
module dual_queue_shared_array #(
  parameter int unsigned DEPTH = dqsa_pkg::DqsaDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request channel.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  input  logic [1:0]  s_axis_tuser,   // [0] req_type, [1] queue_sel
  // Result channel.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] data
  output logic [1:0]  m_axis_tuser    // [1:0] status
);
  import dqsa_pkg::*;

  dqsa_cmd_t cmd;
  dqsa_sts_t sts;

  // The controller, when idle, takes a request whenever the result register is
  // free or being emptied in the same cycle. A successful dequeue parks it in the
  // read state while the memory returns the head word.
  dqsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath holds both queues' pointers and empty flags, checks each
  // request for overflow or underflow, drives the shared memory and holds the
  // result until the downstream side takes it.
  dqsa_dp #(
    .Depth (DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_type_i  (s_axis_tuser[0]),
    .queue_sel_i (s_axis_tuser[1]),
    .value_i     (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_o    (m_axis_tuser),
    .data_o      (m_axis_tdata)
  );

endmodule

@@ sim/dual_queue_shared_array_test.sv @@
// ----------------------------------------------------------------------------
// dual_queue_shared_array_test
// Self-checking bench for the two queues that share one memory.
// ----------------------------------------------------------------------------
// Requests are queued by the stimulus block and presented by a clocked driver.
// At each accepted request, the driver runs the bench's own model of the two
// queues and stores the predicted result. A clocked monitor compares every
// result the block hands out with the oldest prediction.
//
// The stimulus starts with a short directed run:
//   - underflow on both queues,
//   - extreme words on both queues,
//   - a queue drained to empty and then reused,
//   - a dequeue that carries a nonzero word, which must be ignored.
// After that come random phases that fill, drain or mix the queues. These
// phases regularly drive the memory into overflow and both queues back to
// empty.
//
// Backpressure comes from both sides. One long receiver stall lets the block
// back up into its request port.
module dual_queue_shared_array_test;
  import dqsa_pkg::*;

  localparam int unsigned Depth = dqsa_pkg::DqsaDepth;
  localparam int ItemTarget = 1550;
  localparam int StallCycles = 250;
  localparam int StallAfter = 300;

  typedef struct packed {
    req_type_e   kind;
    logic        sel;     // 0 lower queue, 1 upper queue
    logic [31:0] word;
  } request_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] data;
  } outcome_t;

  typedef enum int {
    PH_FILL,
    PH_DRAIN,
    PH_MIXED
  } phase_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;    // [31:0] value
  logic [1:0]  s_axis_tuser = '0;    // [0] req_type, [1] queue_sel
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;         // [31:0] data
  logic [1:0]  m_axis_tuser;         // [1:0] status

  dual_queue_shared_array #(
    .DEPTH(Depth)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #2 clk_i = ~clk_i;

  // Stimulus and scoreboard storage.
  request_t pending_reqs[$];
  outcome_t predicted[$];
  request_t offered_req;
  int       total_reqs = 0;
  int       accepted_cnt = 0;
  int       result_cnt = 0;
  int       fail_cnt = 0;
  int       src_idle_pct = 20;
  int       snk_idle_pct = 52;
  int       stall_left = 0;
  bit       stall_done = 1'b0;

  // The bench's own copy of the queue state. Pointers keep the block's widths.
  logic [31:0] shadow_mem [Depth];
  logic [6:0]  a_head, a_tail, b_head, b_tail;
  logic        a_empty, b_empty;

  // Applies one request to the shadow state and returns the result it gives.
  // Queue A holds shadow_mem[a_head..a_tail], oldest at a_head. Queue B holds
  // shadow_mem[b_tail..b_head], oldest at b_head. Freed head slots are not
  // reused until the queue drains, which puts its pointers back home.
  function automatic outcome_t apply_request(request_t r);
    outcome_t    res;
    int unsigned a_top;
    int unsigned b_bottom;
    res.status = ST_OK;
    res.data   = '0;
    if (r.kind == REQ_ENQ) begin
      // The memory is full when no free slot lies between the two tails.
      a_top    = a_empty ? 0 : int'(a_tail) + 1;
      b_bottom = b_empty ? Depth : int'(b_tail);
      if (a_top >= b_bottom) begin
        res.status = ST_OVERFLOW;
      end else if (r.sel == 1'b0) begin
        if (a_empty) begin
          a_head  = '0;
          a_tail  = '0;
          a_empty = 1'b0;
        end else begin
          a_tail = a_tail + 7'd1;
        end
        shadow_mem[a_tail] = r.word;
      end else begin
        if (b_empty) begin
          b_head  = 7'(Depth - 1);
          b_tail  = 7'(Depth - 1);
          b_empty = 1'b0;
        end else begin
          b_tail = b_tail - 7'd1;
        end
        shadow_mem[b_tail] = r.word;
      end
    end else if (r.sel == 1'b0) begin
      if (a_empty) begin
        res.status = ST_UNDERFLOW;
      end else begin
        res.data = shadow_mem[a_head];
        if (a_head == a_tail) begin
          a_head  = '0;
          a_tail  = '0;
          a_empty = 1'b1;
        end else begin
          a_head = a_head + 7'd1;
        end
      end
    end else begin
      if (b_empty) begin
        res.status = ST_UNDERFLOW;
      end else begin
        res.data = shadow_mem[b_head];
        if (b_head == b_tail) begin
          b_head  = 7'(Depth - 1);
          b_tail  = 7'(Depth - 1);
          b_empty = 1'b1;
        end else begin
          b_head = b_head - 7'd1;
        end
      end
    end
    return res;
  endfunction

  // Request driver. A request that is accepted goes through the model here.
  // A new request is chosen only when the port is free or was just taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      a_head  = '0;
      a_tail  = '0;
      a_empty = 1'b1;
      b_head  = 7'(Depth - 1);
      b_tail  = 7'(Depth - 1);
      b_empty = 1'b1;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predicted.push_back(apply_request(offered_req));
        accepted_cnt <= accepted_cnt + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          offered_req = pending_reqs.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= offered_req.word;
          s_axis_tuser  <= {offered_req.sel, offered_req.kind};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result receiver. Once the stimulus is well under way, it stops taking
  // results for a long stretch so that the block backs up into its request
  // port. Otherwise it stalls at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
      stall_done    <= 1'b0;
    end else if (!stall_done && accepted_cnt >= StallAfter) begin
      m_axis_tready <= 1'b0;
      stall_left    <= StallCycles;
      stall_done    <= 1'b1;
    end else if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Result monitor: every result must match the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      result_cnt <= result_cnt + 1;
      if (predicted.size() == 0) begin
        $error("result with no request outstanding: status %0d data %h",
               m_axis_tuser, m_axis_tdata);
        fail_cnt <= fail_cnt + 1;
      end else begin
        outcome_t exp_res;
        exp_res = predicted.pop_front();
        if (m_axis_tuser !== exp_res.status) begin
          $error("status: expected %0d, got %0d", exp_res.status, m_axis_tuser);
          fail_cnt <= fail_cnt + 1;
        end
        if (m_axis_tdata !== exp_res.data) begin
          $error("data: expected %h, got %h", exp_res.data, m_axis_tdata);
          fail_cnt <= fail_cnt + 1;
        end
      end
    end
  end

  task automatic add_request(req_type_e kind, logic sel, logic [31:0] word);
    request_t r;
    r.kind = kind;
    r.sel  = sel;
    r.word = word;
    pending_reqs.push_back(r);
    total_reqs++;
  endtask

  initial begin
    phase_e      mode;
    int          len;
    int          enq_pct;
    int          a_pct;
    logic [31:0] w;

    // Directed part: underflow on both sides, extreme words, a queue that
    // drains to empty and is then refilled, and dequeues that carry a word.
    add_request(REQ_DEQ, 1'b0, 32'h0);
    add_request(REQ_DEQ, 1'b1, 32'hFFFF_FFFF);
    add_request(REQ_ENQ, 1'b0, 32'h7FFF_FFFF);
    add_request(REQ_ENQ, 1'b0, 32'h8000_0000);
    add_request(REQ_ENQ, 1'b1, 32'hFFFF_FFFF);
    add_request(REQ_ENQ, 1'b1, 32'h0000_0000);
    add_request(REQ_DEQ, 1'b0, 32'hDEAD_BEEF);
    add_request(REQ_DEQ, 1'b0, 32'h0);
    add_request(REQ_DEQ, 1'b0, 32'h0);
    add_request(REQ_DEQ, 1'b1, 32'h0);
    add_request(REQ_ENQ, 1'b1, 32'h5555_5555);
    add_request(REQ_DEQ, 1'b1, 32'h0);
    add_request(REQ_DEQ, 1'b1, 32'h1234_5678);
    add_request(REQ_DEQ, 1'b1, 32'h0);
    add_request(REQ_ENQ, 1'b0, 32'hAAAA_AAAA);
    add_request(REQ_ENQ, 1'b0, 32'h0000_0001);
    add_request(REQ_DEQ, 1'b0, 32'h0);
    add_request(REQ_ENQ, 1'b0, 32'hFFFF_FFFE);
    add_request(REQ_DEQ, 1'b0, 32'h0);
    add_request(REQ_DEQ, 1'b0, 32'h0);
    add_request(REQ_DEQ, 1'b0, 32'h0);

    // Random phases. Fill phases run the shared memory into overflow. Drain
    // phases empty the queues, so their pointers go back to the ends.
    while (total_reqs < ItemTarget) begin
      mode  = phase_e'($urandom_range(2));
      len   = $urandom_range(16, 180);
      a_pct = $urandom_range(100);
      case (mode)
        PH_FILL:  enq_pct = 88;
        PH_DRAIN: enq_pct = 12;
        default:  enq_pct = 50;
      endcase
      for (int i = 0; i < len && total_reqs < ItemTarget; i++) begin
        case ($urandom_range(9))
          0:       w = 32'h7FFF_FFFF;
          1:       w = 32'h8000_0000;
          2:       w = 32'h0;
          3:       w = 32'hFFFF_FFFF;
          default: w = $urandom;
        endcase
        add_request(($urandom_range(99) < enq_pct) ? REQ_ENQ : REQ_DEQ,
                    ($urandom_range(99) < a_pct) ? 1'b0 : 1'b1, w);
      end
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Idle mix: sender light and receiver heavy, then reversed, then none.
    wait (accepted_cnt >= total_reqs / 3);
    src_idle_pct = 52;
    snk_idle_pct = 20;
    wait (accepted_cnt >= (2 * total_reqs) / 3);
    src_idle_pct = 0;
    snk_idle_pct = 0;

    wait (accepted_cnt == total_reqs);
    wait (result_cnt >= accepted_cnt);
    repeat (10) @(posedge clk_i);
    if (fail_cnt == 0 && predicted.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      if (predicted.size() != 0) begin
        $error("%0d predicted results never arrived", predicted.size());
      end
      $display("TEST FAILED");
    end
    $finish;
  end

  // Safety net in case the handshakes hang.
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ dual_queue_shared_array.f @@
hw/rtl/dqsa_pkg.sv
hw/rtl/dqsa_ram.sv
hw/rtl/dqsa_ctrl.sv
hw/rtl/dqsa_dp.sv
hw/rtl/dual_queue_shared_array.sv
sim/dual_queue_shared_array_test.sv
